// File: hw/rtl/afb_pkg.sv
// types, constants and helpers shared by the ascii hex frame builder
`timescale 1ns / 1ps
package afb_pkg;

  // req_type codes
  localparam logic REQ_BEGIN = 1'b0;
  localparam logic REQ_DATA  = 1'b1;

  // configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_SOURCE_ADDRESS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DEST_ADDRESS   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_START_BYTE     = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_END_BYTE       = 2'd3;

  localparam logic [7:0] START_BYTE_RST = 8'h02;
  localparam logic [7:0] END_BYTE_RST   = 8'h03;

  // character positions inside a frame
  localparam int PosW = 4;
  localparam logic [PosW-1:0] POS_START     = 4'd0;
  localparam logic [PosW-1:0] POS_HEX_FIRST = 4'd1;
  localparam logic [PosW-1:0] POS_HEX_LAST  = 4'd12;
  localparam logic [PosW-1:0] POS_DATA      = 4'd12;
  localparam logic [PosW-1:0] POS_SUM_HI    = 4'd13;
  localparam logic [PosW-1:0] POS_SUM_LO    = 4'd14;
  localparam logic [PosW-1:0] POS_END       = 4'd15;

  localparam int HdrBitsW = 48;
  localparam int NibIdxW  = 4;

  typedef enum logic {
    OP_HEADER = 1'b0,
    OP_DATA   = 1'b1
  } op_e;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  command_code;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       run_last;
  } res_t;

  typedef struct packed {
    logic [7:0] source_address;
    logic [7:0] dest_address;
    logic [7:0] start_byte;
    logic [7:0] end_byte;
  } cfg_t;

  // one unit of work for the back end
  typedef struct packed {
    op_e                 op;
    logic                trailer;
    logic [HdrBitsW-1:0] hdr_bits;
    logic [7:0]          start_byte;
    logic [7:0]          end_byte;
    logic [7:0]          data_byte;
  } job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    return (nib < 4'd10) ? (8'h30 + wide) : (8'h37 + wide);
  endfunction

endpackage

// File: hw/rtl/afb_stream_if.sv
// valid/ready stream channel with a typed payload
`timescale 1ns / 1ps
interface afb_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/afb_front.sv
// front end: accepts requests, tracks the open frame and queues work
`timescale 1ns / 1ps
module afb_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  afb_stream_if.sink     req_i,
  input  afb_pkg::cfg_t  cfg_i,
  input  logic           q_full_i,
  output logic           push_o,
  output afb_pkg::job_t  job_o
);

  logic        open_q, open_d;
  logic [15:0] rem_q, rem_d;
  logic        accept;
  afb_pkg::req_t req;

  assign req_i.ready = !q_full_i;
  assign accept = req_i.valid && req_i.ready;
  assign req = req_i.data;

  always_comb begin
    open_d = open_q;
    rem_d  = rem_q;
    push_o = 1'b0;

    job_o.op         = (req.req_type == afb_pkg::REQ_BEGIN) ? afb_pkg::OP_HEADER
                                                             : afb_pkg::OP_DATA;
    job_o.hdr_bits   = {cfg_i.source_address, cfg_i.dest_address, 8'h00,
                        req.command_code, req.payload_length};
    job_o.start_byte = cfg_i.start_byte;
    job_o.end_byte   = cfg_i.end_byte;
    job_o.data_byte  = req.data_byte;
    job_o.trailer    = (req.req_type == afb_pkg::REQ_BEGIN) ? (req.payload_length == 16'd0)
                                                             : (rem_q == 16'd1);

    if (accept) begin
      if (req.req_type == afb_pkg::REQ_BEGIN) begin
        // a new begin drops whatever frame was open
        push_o = 1'b1;
        open_d = (req.payload_length != 16'd0);
        rem_d  = req.payload_length;
      end else if (open_q) begin
        push_o = 1'b1;
        rem_d  = rem_q - 16'd1;
        if (rem_q == 16'd1) begin
          open_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      rem_q  <= 16'd0;
    end else begin
      open_q <= open_d;
      rem_q  <= rem_d;
    end
  end

endmodule

// File: hw/rtl/afb_queue.sv
// small fifo of work items between front and back end
`timescale 1ns / 1ps
module afb_queue #(
  parameter int  Depth   = 2,
  parameter type entry_t = afb_pkg::job_t
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   head_valid_o,
  output entry_t head_data_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_data_o  = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/afb_back.sv
// back end: walks work items one character per cycle, unless stalled, into an output register
`timescale 1ns / 1ps
module afb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  afb_pkg::job_t       head_i,
  output logic                pop_o,
  afb_stream_if.source        res_o
);

  logic                       first_q, first_d;
  logic [afb_pkg::PosW-1:0]   pos_q, pos_d, pos, last_pos;
  logic [7:0]                 sum_q, sum_d;
  logic                       out_valid_q, out_valid_d;
  afb_pkg::res_t              out_q, out_d;
  logic                       load, is_last, summed;
  logic [afb_pkg::NibIdxW-1:0] nib_idx;
  logic [7:0]                 ch;

  assign load = head_valid_i && (!out_valid_q || res_o.ready);

  always_comb begin
    if (first_q) begin
      pos = (head_i.op == afb_pkg::OP_DATA) ? afb_pkg::POS_DATA : afb_pkg::POS_START;
    end else begin
      pos = pos_q;
    end
    last_pos = head_i.trailer ? afb_pkg::POS_END : afb_pkg::POS_DATA;
    is_last  = (pos == last_pos);
    summed   = (pos inside {[afb_pkg::POS_HEX_FIRST : afb_pkg::POS_HEX_LAST]});
    // first hex character takes the top nibble
    nib_idx  = afb_pkg::NibIdxW'(afb_pkg::POS_HEX_LAST - pos);

    case (pos)
      afb_pkg::POS_START:  ch = head_i.start_byte;
      afb_pkg::POS_SUM_HI: ch = afb_pkg::hex_char(sum_q[7:4]);
      afb_pkg::POS_SUM_LO: ch = afb_pkg::hex_char(sum_q[3:0]);
      afb_pkg::POS_END:    ch = head_i.end_byte;
      default: begin
        if (head_i.op == afb_pkg::OP_DATA) begin
          ch = head_i.data_byte;
        end else begin
          ch = afb_pkg::hex_char(head_i.hdr_bits[4*nib_idx +: 4]);
        end
      end
    endcase

    first_d     = first_q;
    pos_d       = pos_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pop_o       = 1'b0;

    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (load) begin
      out_valid_d     = 1'b1;
      out_d.out_byte  = ch;
      out_d.frame_end = (pos == afb_pkg::POS_END);
      out_d.run_last  = is_last;
      if (pos == afb_pkg::POS_START) begin
        sum_d = 8'd0;
      end else if (summed) begin
        sum_d = sum_q + ch;
      end
      if (is_last) begin
        pop_o   = 1'b1;
        first_d = 1'b1;
      end else begin
        first_d = 1'b0;
        pos_d   = pos + 1'b1;
      end
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= 1'b1;
      pos_q       <= afb_pkg::POS_START;
      sum_q       <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      first_q     <= first_d;
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

// File: hw/rtl/ascii_hex_frame_builder_top.sv
// top level of the ascii hex frame builder
//
//   channel   dir  handshake          payload
//   req_i     in   valid / ready      req_type, command_code, payload_length, data_byte
//   res_o     out  valid / ready      out_byte, frame_end, run_last
//   cfg       in   cfg_we_i           cfg_idx_i, cfg_data_i (write only)
//
// the back end puts out one character per cycle while res_o is taken: a begin gives 13
// characters (16 with a zero length), a payload byte 1 character (4 with the trailer)
// the front end takes a request per cycle while the work queue has room
// a payload request outside a frame is absorbed in the front end
// asynchronous active-low reset clears frame state, queue and output valid, and resets the configuration
`timescale 1ns / 1ps
module ascii_hex_frame_builder_top #(
  parameter int QueueDepth = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  afb_stream_if.sink                    req_i,
  afb_stream_if.source                  res_o,
  input  logic                          cfg_we_i,
  input  logic [afb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [7:0]                    cfg_data_i
);

  afb_pkg::cfg_t cfg_q;
  afb_pkg::job_t push_job, head_job;
  logic          push, q_full, head_valid, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_address <= 8'd0;
      cfg_q.dest_address   <= 8'd0;
      cfg_q.start_byte     <= afb_pkg::START_BYTE_RST;
      cfg_q.end_byte       <= afb_pkg::END_BYTE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        afb_pkg::CFG_SOURCE_ADDRESS: cfg_q.source_address <= cfg_data_i;
        afb_pkg::CFG_DEST_ADDRESS:   cfg_q.dest_address   <= cfg_data_i;
        afb_pkg::CFG_START_BYTE:     cfg_q.start_byte     <= cfg_data_i;
        afb_pkg::CFG_END_BYTE:       cfg_q.end_byte       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  afb_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .cfg_i    (cfg_q),
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (push_job)
  );

  afb_queue #(
    .Depth   (QueueDepth),
    .entry_t (afb_pkg::job_t)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_job),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_data_o  (head_job)
  );

  afb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_job),
    .pop_o        (pop),
    .res_o        (res_o)
  );

endmodule

// File: hw/rtl/afb_checker.sv
// port-level checks for the ascii hex frame builder, bound to the top level
`timescale 1ns / 1ps
module afb_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  afb_stream_if.sink                  req_i,
  afb_stream_if.source                res_o,
  input  logic                        cfg_we_i,
  input  logic [afb_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]                  cfg_data_i
);

  // a stalled result stays offered
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |=> res_o.valid)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |=> $stable(res_o.data))
    else $error("result changed while stalled");

  // the end character always closes the run of its request
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.data.frame_end |-> res_o.data.run_last)
    else $error("frame end not last of its request");

  // request side only backs up when queued work is already showing
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> res_o.valid)
    else $error("requests stalled with no result offered");

endmodule

bind ascii_hex_frame_builder_top afb_checker u_afb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .req_i      (req_i),
  .res_o      (res_o),
  .cfg_we_i   (cfg_we_i),
  .cfg_idx_i  (cfg_idx_i),
  .cfg_data_i (cfg_data_i)
);
